### rtl/pwm_setpoint_command_decoder_core_assert.svh
// ---------------------------------------------------------------------------
// PWM setpoint command decoder assertion macros
// Shorthand for clocked assertions with the synchronous reset as disable.
// ---------------------------------------------------------------------------
`ifndef PWM_SETPOINT_COMMAND_DECODER_CORE_ASSERT_SVH
`define PWM_SETPOINT_COMMAND_DECODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define PSCD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("pscd check failed");

// Next-cycle implication.
`define PSCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("pscd check failed");

`endif

### rtl/pscd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PWM setpoint command decoder package
// Character codes, arithmetic constants and the types passed between stages.
// ---------------------------------------------------------------------------
package pscd_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_START = 8'h3A;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_T     = 8'h54;

  localparam logic [15:0] PERIOD_RESET = 16'hFFFF;

  // Division by 100 of a 32-bit product: multiply by ceil(2^38 / 100), shift by 38.
  localparam logic [31:0] DIV100_RECIP = 32'd2748779070;
  localparam int          DIV100_SHIFT = 38;

  localparam logic KIND_PERIOD  = 1'b0;
  localparam logic KIND_COMPARE = 1'b1;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic        load;
    logic [31:0] data;
  } report_req_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] value;
  } report_t;

endpackage

### rtl/pwm_setpoint_command_decoder_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PWM setpoint command decoder core
// Decodes ':'-framed serial commands that set the PWM period and duty compare.
// ---------------------------------------------------------------------------
// One received byte is taken per word and a byte can be accepted every cycle
// while in_tready is high. A ':' opens a command, the next byte is the letter
// and the rest is a decimal argument; a carriage return closes it. 'T' loads
// the period, 'D' sets the compare to argument times period over 100. Both
// register the report request as the carriage return is taken, with the
// argument-by-period product for 'D', and the following cycle divides that
// product by 100 through a reciprocal multiply on its way into the queue.
// Reports wait in a two-entry queue, and in_tready falls only while that queue
// and the report in flight together fill both entries.
module pwm_setpoint_command_decoder_core
  import pscd_pkg::*;
#(
  parameter int MAX_CMD_LEN = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] report_value
  output logic        out_tuser   // [0] report_kind
);

  report_req_t req;
  logic        res_valid;
  report_t     res;
  report_t     head;
  logic [1:0]  occupancy;
  logic        in_fire;

  assign in_tready = (occupancy == 2'd0) || (occupancy == 2'd1 && !req.valid);
  assign in_fire   = in_tvalid && in_tready;

  pscd_parser #(
    .MAX_CMD_LEN (MAX_CMD_LEN)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_fire),
    .byte_data  (in_tdata),
    .req        (req)
  );

  pscd_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .res_valid (res_valid),
    .res       (res)
  );

  pscd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_valid  (res_valid),
    .wr_data   (res),
    .occupancy (occupancy),
    .rd_valid  (out_tvalid),
    .rd_ready  (out_tready),
    .rd_data   (head)
  );

  assign out_tdata = head.value;
  assign out_tuser = head.kind;

endmodule

### rtl/pscd_out_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PWM setpoint command decoder output queue
// Two-entry queue that holds report words until the output side takes them.
// ---------------------------------------------------------------------------
module pscd_out_fifo
  import pscd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_valid,
  input  report_t     wr_data,
  output logic [1:0]  occupancy,
  output logic        rd_valid,
  input  logic        rd_ready,
  output report_t     rd_data
);

  report_t    mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       pop;

  assign pop       = rd_valid && rd_ready;
  assign rd_valid  = (cnt_r != 2'd0);
  assign rd_data   = mem_r[rd_ptr_r];
  assign occupancy = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_valid ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, wr_valid} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### rtl/pscd_scale.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PWM setpoint command decoder scaling stage
// Divides the duty product by 100, holds the compare register and forms the
// report word.
// ---------------------------------------------------------------------------
module pscd_scale
  import pscd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  report_req_t req,
  output logic        res_valid,
  output report_t     res
);

  logic [15:0] compare_r;
  logic [15:0] compare_nxt;
  logic [63:0] quot_full;
  logic [15:0] quot;

  assign quot_full = {32'd0, req.data} * {32'd0, DIV100_RECIP};
  assign quot      = quot_full[DIV100_SHIFT +: 16];
  assign res_valid = req.valid;

  always_comb begin
    compare_nxt = compare_r;
    res.kind    = req.kind;
    res.value   = req.data[15:0];
    if (req.kind == KIND_COMPARE) begin
      if (req.load) begin
        res.value = quot;
        if (req.valid) begin
          compare_nxt = quot;
        end
      end else begin
        res.value = compare_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compare_r <= 16'd0;
    end else begin
      compare_r <= compare_nxt;
    end
  end

endmodule

### rtl/pscd_parser.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PWM setpoint command decoder byte parser
// Tracks the open command, parses the argument a byte at a time, holds the
// period register and issues report requests for 'T' and 'D' on a CR.
// ---------------------------------------------------------------------------
module pscd_parser
  import pscd_pkg::*;
#(
  parameter int MAX_CMD_LEN = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_valid,
  input  logic [7:0]  byte_data,
  output report_req_t req
);

  localparam int               CNT_W     = $clog2(MAX_CMD_LEN);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_CMD_LEN - 1);

  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  logic             in_cmd_r,  in_cmd_nxt;
  logic [CNT_W-1:0] count_r,   count_nxt;
  logic [7:0]       letter_r,  letter_nxt;
  logic [1:0]       phase_r,   phase_nxt;
  logic             neg_r,     neg_nxt;
  logic             present_r, present_nxt;
  logic [15:0]      value_r,   value_nxt;
  logic [15:0]      period_r,  period_nxt;
  report_req_t      req_r,     req_nxt;

  logic        is_space;
  logic        is_digit;
  logic [15:0] value_x10;
  logic [15:0] arg;
  logic [31:0] product;

  always_comb begin
    is_space  = (byte_data inside {[CH_TAB:CH_FF], CH_SPACE});
    is_digit  = (byte_data inside {[CH_ZERO:CH_NINE]});
    value_x10 = {value_r[12:0], 3'b000} + {value_r[14:0], 1'b0} + {12'd0, byte_data[3:0]};
    arg       = neg_r ? (~value_r + 16'd1) : value_r;
    product   = {16'd0, arg} * {16'd0, period_r};
  end

  always_comb begin
    in_cmd_nxt  = in_cmd_r;
    count_nxt   = count_r;
    letter_nxt  = letter_r;
    phase_nxt   = phase_r;
    neg_nxt     = neg_r;
    present_nxt = present_r;
    value_nxt   = value_r;
    period_nxt  = period_r;
    req_nxt     = '0;
    if (byte_valid) begin
      if (byte_data == CH_START) begin
        in_cmd_nxt  = 1'b1;
        count_nxt   = '0;
        letter_nxt  = CH_NUL;
        phase_nxt   = PH_SKIP;
        neg_nxt     = 1'b0;
        present_nxt = 1'b0;
        value_nxt   = 16'd0;
      end else if (in_cmd_r) begin
        if (byte_data == CH_CR) begin
          in_cmd_nxt = 1'b0;
          if (letter_r == CH_T) begin
            if (present_r) begin
              period_nxt = arg;
            end
            req_nxt.valid = 1'b1;
            req_nxt.kind  = KIND_PERIOD;
            req_nxt.load  = present_r;
            req_nxt.data  = {16'd0, present_r ? arg : period_r};
          end else if (letter_r == CH_D) begin
            req_nxt.valid = 1'b1;
            req_nxt.kind  = KIND_COMPARE;
            req_nxt.load  = present_r;
            req_nxt.data  = product;
          end
        end else if (count_r < CNT_LIMIT) begin
          count_nxt = count_r + CNT_W'(1);
          if (count_r == '0) begin
            letter_nxt = byte_data;
          end else if (phase_r == PH_SKIP || phase_r == PH_DIGITS) begin
            if (byte_data == CH_NUL) begin
              phase_nxt = PH_DONE;
            end else begin
              present_nxt = 1'b1;
              if (phase_r == PH_SKIP && is_space) begin
                phase_nxt = PH_SKIP;
              end else if (phase_r == PH_SKIP &&
                           (byte_data == CH_PLUS || byte_data == CH_MINUS)) begin
                neg_nxt   = (byte_data == CH_MINUS);
                phase_nxt = PH_DIGITS;
              end else if (is_digit) begin
                value_nxt = value_x10;
                phase_nxt = PH_DIGITS;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cmd_r  <= 1'b0;
      count_r   <= '0;
      letter_r  <= CH_NUL;
      phase_r   <= PH_SKIP;
      neg_r     <= 1'b0;
      present_r <= 1'b0;
      value_r   <= 16'd0;
      period_r  <= PERIOD_RESET;
      req_r     <= '0;
    end else begin
      in_cmd_r  <= in_cmd_nxt;
      count_r   <= count_nxt;
      letter_r  <= letter_nxt;
      phase_r   <= phase_nxt;
      neg_r     <= neg_nxt;
      present_r <= present_nxt;
      value_r   <= value_nxt;
      period_r  <= period_nxt;
      req_r     <= req_nxt;
    end
  end

  assign req = req_r;

endmodule

### rtl/pscd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PWM setpoint command decoder port checker
// Watches the top-level ports for handshake and report timing errors.
// ---------------------------------------------------------------------------
`include "pwm_setpoint_command_decoder_core_assert.svh"

module pscd_checker
  import pscd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  `PSCD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `PSCD_ASSERT_SAME(a_stall_needs_backlog, !in_tready, out_tvalid)
  `PSCD_ASSERT_NEXT(a_start_no_report, in_tvalid && in_tready && in_tdata == CH_START, ##1 !$rose(out_tvalid))

endmodule

bind pwm_setpoint_command_decoder_core pscd_checker u_pscd_checker (.*);
